@@ hw/rtl/dtd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dtd_pkg;

    localparam int TASK_IDS = 64;
    localparam int ID_W     = $clog2(TASK_IDS);

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_CMPL,
        OP_RST
    } t_op;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_SCHED,
        TS_DONE
    } t_tstate;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_PFULL   = 3'd2;
    localparam logic [2:0] STAT_BADPUSH = 3'd3;
    localparam logic [2:0] STAT_REFUSED = 3'd4;

    typedef struct packed {
        t_op             opcode;
        logic [ID_W-1:0] task_id;
        logic [ID_W-1:0] parent_id;
        logic            has_parent;
    } t_req;

    typedef struct packed {
        logic [2:0]      status;
        logic            popped_valid;
        logic [ID_W-1:0] popped_task;
        logic [4:0]      remaining;
        logic            all_done;
    } t_rsp;

    // query record that ripples down the chain, one cell per cycle
    typedef struct packed {
        logic            go;
        logic [ID_W-1:0] tid;
        logic [ID_W-1:0] pid;
        logic            hit;
        t_tstate         hit_stat;
        logic            hit_full;
        logic            par_done;
        logic            rdy_found;
        logic [ID_W-1:0] rdy_task;
    } t_scan;

    // update broadcast to every cell at once
    typedef struct packed {
        logic            en;
        t_op             kind;
        logic            is_new;
        logic            append;
        logic            pdone;
        logic [ID_W-1:0] tid;
        logic [ID_W-1:0] pid;
    } t_apply;

endpackage
`default_nettype wire

@@ hw/rtl/dtd_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface dtd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dtd_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtd_cell #(
    parameter int MAX_PREREQS = 4,
    parameter int IDX         = 0,
    parameter int CNT_W       = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dtd_pkg::t_scan    i_scan,
    output dtd_pkg::t_scan         o_scan,
    input  wire dtd_pkg::t_apply   i_apply,
    input  wire logic [CNT_W-1:0]  i_cnt
);
    import dtd_pkg::*;

    localparam int PC_W = $clog2(MAX_PREREQS + 1);
    localparam int PI_W = (MAX_PREREQS > 1) ? $clog2(MAX_PREREQS) : 1;

    logic                   r_valid;
    logic [ID_W-1:0]        r_task;
    t_tstate                r_stat;
    logic [PC_W-1:0]        r_pcnt;
    logic [ID_W-1:0]        r_pre [MAX_PREREQS];
    logic [MAX_PREREQS-1:0] r_pdone;
    t_scan                  r_scan;
    t_scan                  n_scan;

    logic            all_pdone;
    logic            match;
    logic            place;
    logic [PI_W-1:0] wa;

    // check that every listed prerequisite is done
    always_comb begin
        all_pdone = 1'b1;
        for (int k = 0; k < MAX_PREREQS; k++) begin
            if (PC_W'(k) < r_pcnt && !r_pdone[k]) begin
                all_pdone = 1'b0;
            end
        end
    end

    // merge this entry into the passing query
    always_comb begin
        n_scan = i_scan;
        if (r_valid && r_task == i_scan.tid) begin
            n_scan.hit      = 1'b1;
            n_scan.hit_stat = r_stat;
            n_scan.hit_full = (r_pcnt == PC_W'(MAX_PREREQS));
        end
        if (r_valid && r_task == i_scan.pid && r_stat == TS_DONE) begin
            n_scan.par_done = 1'b1;
        end
        if (!i_scan.rdy_found && r_valid && r_stat == TS_IDLE && all_pdone) begin
            n_scan.rdy_found = 1'b1;
            n_scan.rdy_task  = r_task;
        end
    end

    // the entry count has already advanced when the update arrives
    assign match  = r_valid && r_task == i_apply.tid;
    assign place  = i_apply.is_new && i_cnt == CNT_W'(IDX + 1);
    assign wa     = r_pcnt[PI_W-1:0];
    assign o_scan = r_scan;

    // hand the query on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.go <= 1'b0;
        end else begin
            r_scan <= n_scan;
        end
    end

    // apply the broadcast update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_apply.en) begin
            case (i_apply.kind)
                OP_PUSH: begin
                    if (place) begin
                        r_valid    <= 1'b1;
                        r_task     <= i_apply.tid;
                        r_stat     <= TS_IDLE;
                        r_pcnt     <= i_apply.append ? PC_W'(1) : '0;
                        r_pre[0]   <= i_apply.pid;
                        r_pdone[0] <= i_apply.pdone;
                    end else if (match && i_apply.append) begin
                        r_pre[wa]   <= i_apply.pid;
                        r_pdone[wa] <= i_apply.pdone;
                        r_pcnt      <= r_pcnt + PC_W'(1);
                    end
                end
                OP_POP: begin
                    if (match) begin
                        r_stat <= TS_SCHED;
                    end
                end
                OP_CMPL: begin
                    if (match) begin
                        r_stat <= TS_DONE;
                    end
                    for (int k = 0; k < MAX_PREREQS; k++) begin
                        if (PC_W'(k) < r_pcnt && r_pre[k] == i_apply.tid) begin
                            r_pdone[k] <= 1'b1;
                        end
                    end
                end
                OP_RST: begin
                    r_stat  <= TS_IDLE;
                    r_pdone <= '0;
                end
                default: begin
                    r_stat <= r_stat;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/dependency_task_dispatcher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Dependency task dispatcher. Tasks live in a row of MAX_ENTRIES cells in
// insertion order; each cell holds its task id, state and prerequisite list
// with a done flag per prerequisite. Each request launches a query that
// walks the row one cell per cycle, then the decided update is broadcast to
// all cells. The result is loaded into the output register after the walk
// along the cell row and the decision, and the next request can be accepted
// once the dispatcher is back in idle. One request is worked on at a time;
// the next is accepted while a result waits in the output register, and its
// result is held back until that register is free. Task ids use the full id
// field, which spans exactly the TASK_IDS ids.
module dependency_task_dispatcher #(
    parameter int MAX_ENTRIES = 16,
    parameter int MAX_PREREQS = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dtd_stream_if.sink   i_req,
    dtd_stream_if.source o_rsp
);
    import dtd_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    t_state           r_state;
    t_req             r_req;
    t_scan            r_launch;
    t_scan            r_res;
    t_apply           r_apply;
    t_apply           n_apply;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_unsch, n_unsch;
    logic [CNT_W-1:0] r_done, n_done;
    logic             r_ovalid;
    t_rsp             r_odata;
    t_rsp             n_odata;
    t_scan            w_scan [MAX_ENTRIES+1];
    t_req             in_req;

    assign in_req      = i_req.data;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;
    assign w_scan[0]   = r_launch;

    // cell row
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        dtd_cell #(
            .MAX_PREREQS (MAX_PREREQS),
            .IDX         (g),
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_scan  (w_scan[g]),
            .o_scan  (w_scan[g+1]),
            .i_apply (r_apply),
            .i_cnt   (r_cnt)
        );
    end

    // decide the outcome from the gathered query
    always_comb begin
        n_apply     = '0;
        n_apply.tid = r_req.task_id;
        n_apply.pid = r_req.parent_id;
        n_cnt       = r_cnt;
        n_unsch     = r_unsch;
        n_done      = r_done;
        n_odata     = '0;
        case (r_req.opcode)
            OP_PUSH: begin
                if (r_req.has_parent && r_req.task_id == r_req.parent_id) begin
                    n_odata.status = STAT_BADPUSH;
                end else if (r_res.hit && r_res.hit_stat != TS_IDLE) begin
                    n_odata.status = STAT_BADPUSH;
                end else if (!r_res.hit && r_cnt >= CNT_W'(MAX_ENTRIES)) begin
                    n_odata.status = STAT_FULL;
                end else if (r_res.hit && r_req.has_parent && r_res.hit_full) begin
                    n_odata.status = STAT_PFULL;
                end else begin
                    n_apply.en     = 1'b1;
                    n_apply.kind   = OP_PUSH;
                    n_apply.is_new = !r_res.hit;
                    n_apply.append = r_req.has_parent;
                    n_apply.pdone  = r_res.par_done;
                    if (!r_res.hit) begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_unsch = r_unsch + CNT_W'(1);
                    end
                end
            end
            OP_POP: begin
                if (r_res.rdy_found) begin
                    n_apply.en           = 1'b1;
                    n_apply.kind         = OP_POP;
                    n_apply.tid          = r_res.rdy_task;
                    n_odata.popped_valid = 1'b1;
                    n_odata.popped_task  = r_res.rdy_task;
                    if (r_unsch != '0) begin
                        n_unsch = r_unsch - CNT_W'(1);
                    end
                end
            end
            OP_CMPL: begin
                if (r_res.hit && r_res.hit_stat == TS_SCHED) begin
                    n_apply.en   = 1'b1;
                    n_apply.kind = OP_CMPL;
                    n_done       = r_done + CNT_W'(1);
                end
            end
            OP_RST: begin
                if (r_unsch != '0 || r_done != r_cnt) begin
                    n_odata.status = STAT_REFUSED;
                end else begin
                    n_apply.en   = 1'b1;
                    n_apply.kind = OP_RST;
                    n_unsch      = r_cnt;
                    n_done       = '0;
                end
            end
            default: begin
                n_odata.status = STAT_OK;
            end
        endcase
        n_odata.remaining = 5'(n_unsch);
        n_odata.all_done  = (n_done == n_cnt);
    end

    // sequence accept, walk, decide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch.go <= 1'b0;
            r_apply.en  <= 1'b0;
            r_cnt       <= '0;
            r_unsch     <= '0;
            r_done      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            // drop a taken result unless a new one loads this cycle
            if (o_rsp.ready && r_state != S_DECIDE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_apply.en <= 1'b0;
                    if (i_req.valid) begin
                        r_req    <= in_req;
                        r_launch <= '{go: 1'b1, tid: in_req.task_id,
                                      pid: in_req.parent_id, hit: 1'b0,
                                      hit_stat: TS_IDLE, hit_full: 1'b0,
                                      par_done: 1'b0, rdy_found: 1'b0,
                                      rdy_task: '0};
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_launch.go <= 1'b0;
                    if (w_scan[MAX_ENTRIES].go) begin
                        r_res   <= w_scan[MAX_ENTRIES];
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_apply  <= n_apply;
                        r_cnt    <= n_cnt;
                        r_unsch  <= n_unsch;
                        r_done   <= n_done;
                        r_odata  <= n_odata;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import dtd_pkg::*;

    localparam int ENTRIES   = 16;
    localparam int PREREQS   = 4;
    localparam int IDS       = 64;
    localparam int STALL_MAX = 20000;

    logic i_clk;
    logic i_rst_n;

    dtd_stream_if #(.T(t_req)) req_if ();
    dtd_stream_if #(.T(t_rsp)) rsp_if ();

    dependency_task_dispatcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // scoreboard model of the dispatcher state
    t_tstate    id_state[IDS];
    logic [5:0] row_task[ENTRIES];
    int         row_npre[ENTRIES];
    logic [5:0] row_pre[ENTRIES][PREREQS];
    int         row_count;
    int         unsched;

    t_rsp pending_rsp[$];
    int   mismatches;
    int   send_idle_pct;
    int   rcv_idle_pct;
    int   hold_left;
    int   quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit listed_done();
        for (int i = 0; i < row_count; i++) begin
            if (id_state[row_task[i]] != TS_DONE) return 0;
        end
        return 1;
    endfunction

    function automatic bit row_ready(int e);
        for (int k = 0; k < row_npre[e]; k++) begin
            if (id_state[row_pre[e][k]] != TS_DONE) return 0;
        end
        return 1;
    endfunction

    function automatic int find_row(logic [5:0] id);
        for (int i = 0; i < row_count; i++) begin
            if (row_task[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic logic [2:0] model_push(logic [5:0] child, logic [5:0] par, bit hp);
        int e;
        if (hp && child == par) return STAT_BADPUSH;
        if (id_state[child] != TS_IDLE) return STAT_BADPUSH;
        e = find_row(child);
        if (e < 0 && row_count >= ENTRIES) return STAT_FULL;
        if (e >= 0 && hp && row_npre[e] >= PREREQS) return STAT_PFULL;
        if (e < 0) begin
            e = row_count;
            row_task[e] = child;
            row_npre[e] = 0;
            row_count++;
            unsched++;
        end
        if (hp) begin
            row_pre[e][row_npre[e]] = par;
            row_npre[e]++;
        end
        return STAT_OK;
    endfunction

    // work out the response to one request and advance the model
    function automatic t_rsp dispatch_model(t_req r);
        t_rsp o;
        o = '0;
        case (r.opcode)
            OP_PUSH: o.status = model_push(r.task_id, r.parent_id, r.has_parent);
            OP_POP: begin
                for (int i = 0; i < row_count; i++) begin
                    if (id_state[row_task[i]] == TS_IDLE && row_ready(i)) begin
                        id_state[row_task[i]] = TS_SCHED;
                        if (unsched > 0) unsched--;
                        o.popped_valid = 1'b1;
                        o.popped_task  = row_task[i];
                        break;
                    end
                end
            end
            OP_CMPL: begin
                if (id_state[r.task_id] == TS_SCHED) id_state[r.task_id] = TS_DONE;
            end
            default: begin
                if (unsched != 0 || !listed_done()) begin
                    o.status = STAT_REFUSED;
                end else begin
                    for (int i = 0; i < row_count; i++) id_state[row_task[i]] = TS_IDLE;
                    unsched = row_count;
                end
            end
        endcase
        o.remaining = unsched[4:0];
        o.all_done  = listed_done();
        return o;
    endfunction

    // predict at each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready)
            pending_rsp = {pending_rsp, dispatch_model(req_if.data)};
    end

    // compare each accepted response with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", rsp_if.data);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_if.data.status !== want.status ||
                    rsp_if.data.popped_valid !== want.popped_valid ||
                    rsp_if.data.popped_task !== want.popped_task ||
                    rsp_if.data.remaining !== want.remaining ||
                    rsp_if.data.all_done !== want.all_done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response mismatch: expected %p actual %p",
                                 want, rsp_if.data);
                end
            end
        end
    end

    // drive response ready, with random stalls and long holds
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            rsp_if.ready <= ($urandom % 100) >= rcv_idle_pct;
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one request; returns at the falling edge after acceptance
    task automatic send_req(t_op op, logic [5:0] tid, logic [5:0] pid, bit hp);
        t_req r;
        r.opcode     = op;
        r.task_id    = tid;
        r.parent_id  = pid;
        r.has_parent = hp;
        while (($urandom % 100) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_req(OP_POP, 6'd0, 6'd0, 1'b0);      // empty pop
        send_req(OP_RST, 6'd0, 6'd0, 1'b0);      // reset of empty table
        send_req(OP_PUSH, 6'd0, 6'd63, 1'b0);
        send_req(OP_PUSH, 6'd63, 6'd10, 1'b1);   // prerequisite not yet listed
        send_req(OP_PUSH, 6'd63, 6'd63, 1'b1);   // push onto itself
        send_req(OP_POP, 6'd0, 6'd0, 1'b0);
        send_req(OP_PUSH, 6'd0, 6'd5, 1'b0);     // busy child
        send_req(OP_CMPL, 6'd5, 6'd0, 1'b0);     // complete of idle task
        send_req(OP_RST, 6'd0, 6'd0, 1'b0);      // refused
        repeat (3) send_req(OP_PUSH, 6'd63, 6'd0, 1'b1);
        send_req(OP_PUSH, 6'd63, 6'd0, 1'b1);    // prerequisite list full
        send_req(OP_POP, 6'd0, 6'd0, 1'b0);      // blocked on unlisted id
        send_req(OP_CMPL, 6'd0, 6'd0, 1'b0);
        send_req(OP_PUSH, 6'd10, 6'd0, 1'b0);
        send_req(OP_POP, 6'd0, 6'd0, 1'b0);
        send_req(OP_CMPL, 6'd10, 6'd0, 1'b0);
        send_req(OP_POP, 6'd0, 6'd0, 1'b0);
        send_req(OP_CMPL, 6'd63, 6'd0, 1'b0);
        send_req(OP_RST, 6'd0, 6'd0, 1'b0);      // granted
        drain();
    endtask

    // one random request, mostly well-formed dependency traffic
    task automatic send_random();
        int         roll;
        int         e;
        int         n;
        logic [5:0] tid;
        logic [5:0] pid;
        bit         hp;
        logic [5:0] sched[$];
        roll = $urandom % 100;
        tid  = 6'($urandom_range(0, IDS - 1));
        pid  = 6'($urandom_range(0, IDS - 1));
        hp   = 1'($urandom % 2);
        if (roll < 12) begin
            // noise; pushes are kept to self references so no cycle forms
            send_req(t_op'($urandom % 4), tid, tid, 1'b1);
        end else if (roll < 42) begin
            e = find_row(tid);
            n = (e >= 0) ? e : row_count;
            if (hp && n > 0) pid = row_task[$urandom_range(0, n - 1)];
            else hp = 0;
            send_req(OP_PUSH, tid, pid, hp);
        end else if (roll < 68) begin
            send_req(OP_POP, tid, pid, hp);
        end else if (roll < 90) begin
            for (int i = 0; i < row_count; i++)
                if (id_state[row_task[i]] == TS_SCHED) sched = {sched, row_task[i]};
            if (sched.size() > 0) tid = sched[$urandom_range(0, sched.size() - 1)];
            send_req(OP_CMPL, tid, pid, hp);
        end else begin
            send_req(OP_RST, tid, pid, hp);
        end
    endtask

    task automatic test_random(int items, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        rcv_idle_pct  = r_pct;
        repeat (items) send_random();
    endtask

    task automatic test_backpressure(int items);
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        hold_left     = 300;
        repeat (items) send_random();
        drain();
    endtask

    initial begin
        mismatches    = 0;
        quiet_cycles  = 0;
        hold_left     = 0;
        send_idle_pct = 38;
        rcv_idle_pct  = 86;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        for (int i = 0; i < IDS; i++) id_state[i] = TS_IDLE;
        row_count = 0;
        unsched   = 0;
        i_rst_n   = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(200, 38, 86);
        test_random(200, 86, 38);
        drain();
        test_random(200, 0, 0);
        test_backpressure(30);

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/dtd_pkg.sv
hw/rtl/dtd_stream_if.sv
hw/rtl/dtd_cell.sv
hw/rtl/dependency_task_dispatcher.sv
tb/tb.sv
